[rtl/assert_macros.svh]
// assertion macros, included by the rtl of deferred_message_ring_queue
// no dependencies; each use names its own clock and active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/dmrq_pkg.sv]
// types, constants and the control store of the deferred message ring queue
// no dependencies
package dmrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KIND_W      = 4;
    localparam int SPACE_W     = 12;
    localparam int LEN_W       = 8;
    localparam int LEN_REGS    = 4;
    localparam int LEN_IDX_W   = 2;

    localparam logic [LEN_W-1:0] LEN_RESET [LEN_REGS] = '{8'd9, 8'd28, 8'd28, 8'd51};

    localparam logic ITEM_SENT  = 1'b0;
    localparam logic ITEM_FINAL = 1'b1;

    typedef enum logic [2:0] {
        OC_SENT     = 3'd0,
        OC_DEFERRED = 3'd1,
        OC_DUP      = 3'd2,
        OC_FULL     = 3'd3,
        OC_RETRY    = 3'd4
    } t_outcome;

    typedef struct packed {
        logic              channel;
        logic [KIND_W-1:0] message_kind;
        logic              retry_only;
        logic [SPACE_W-1:0] tx_space;
    } t_req;

    typedef struct packed {
        logic              item_kind;
        logic [KIND_W-1:0] sent_kind;
        t_outcome          outcome;
        logic [4:0]        queued_after;
        logic              last_item;
    } t_rsp;

    // sequencer step addresses
    typedef enum logic [2:0] {
        ST_WAIT       = 3'd0,
        ST_DRAIN_RD   = 3'd1,
        ST_DRAIN_SEND = 3'd2,
        ST_SCAN_INIT  = 3'd3,
        ST_SCAN_RD    = 3'd4,
        ST_SCAN_CMP   = 3'd5,
        ST_DECIDE     = 3'd6,
        ST_FINAL      = 3'd7
    } t_step;

    // jump conditions
    typedef enum logic [2:0] {
        C_REQ      = 3'd0,
        C_EMPTY    = 3'd1,
        C_NOFIT    = 3'd2,
        C_RETRY    = 3'd3,
        C_SCAN_END = 3'd4,
        C_MATCH    = 3'd5,
        C_ALWAYS   = 3'd6
    } t_cond;

    typedef struct packed {
        t_cond cond;
        logic  rd_head;
        logic  rd_scan;
        logic  drain;
        logic  scan_init;
        logic  dup_chk;
        logic  decide;
        logic  final_emit;
        t_step tgt;
        t_step fall;
    } t_uword;

    // control store: jump to tgt when cond holds, else go to fall
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            ST_WAIT:       w = '{C_REQ,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 ST_DRAIN_RD, ST_WAIT};
            ST_DRAIN_RD:   w = '{C_EMPTY,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 ST_SCAN_INIT, ST_DRAIN_SEND};
            ST_DRAIN_SEND: w = '{C_NOFIT,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                 ST_SCAN_INIT, ST_DRAIN_RD};
            ST_SCAN_INIT:  w = '{C_RETRY,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                 ST_FINAL, ST_SCAN_RD};
            ST_SCAN_RD:    w = '{C_SCAN_END, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 ST_DECIDE, ST_SCAN_CMP};
            ST_SCAN_CMP:   w = '{C_MATCH,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                                 ST_DECIDE, ST_SCAN_RD};
            ST_DECIDE:     w = '{C_ALWAYS,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                 ST_FINAL, ST_FINAL};
            ST_FINAL:      w = '{C_ALWAYS,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                 ST_WAIT, ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

[rtl/deferred_message_ring_queue.sv]
// deferred message ring queue: microcoded sequencer, ring memory and output register
// depends on dmrq_pkg and assert_macros.svh
//
// Usage: a request (channel, message_kind, retry_only, tx_space) enters on
// i_in_valid/o_in_ready. The block first sends queued kinds of that channel
// from the ring head while each still fits in the space left, then, unless
// retry_only is set, handles the new kind: dropped if already queued, sent if
// the ring is empty and it fits, else appended, or dropped when the ring is full.
// Each send comes out as a result on o_out_valid/i_out_ready, followed by one
// final result with the outcome and the remaining ring occupancy (last_item set).
// One request is worked at a time; o_in_ready is high only between requests.
// Each ring entry compared for a duplicate and each queued kind read for
// sending costs a read of the ring memory.
// Length registers are written on i_cfg_we and are used as they stand, also by a request in progress.
// Reset empties every ring and loads the default lengths; ring contents stay
// as they are. A stalled receiver holds the sequencer at the next result.
module deferred_message_ring_queue #(
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dmrq_pkg::t_req                 i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dmrq_pkg::t_rsp                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic [dmrq_pkg::LEN_IDX_W-1:0] i_cfg_idx,
    input  logic [dmrq_pkg::LEN_W-1:0]     i_cfg_data
);

`include "assert_macros.svh"

    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int DEPTH  = CHANNEL_COUNT * dmrq_pkg::QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int PTR_W   = dmrq_pkg::PTR_W;
    localparam int CNT_W   = dmrq_pkg::CNT_W;
    localparam int KIND_W  = dmrq_pkg::KIND_W;
    localparam int SPACE_W = dmrq_pkg::SPACE_W;
    localparam int LEN_W   = dmrq_pkg::LEN_W;

    dmrq_pkg::t_step    r_step, n_step;
    dmrq_pkg::t_uword   uw;
    dmrq_pkg::t_outcome r_outcome;

    logic [LEN_W-1:0]   r_len   [dmrq_pkg::LEN_REGS];
    logic [PTR_W-1:0]   r_head  [CHANNEL_COUNT];
    logic [CNT_W-1:0]   r_count [CHANNEL_COUNT];
    logic [KIND_W-1:0]  r_mem   [DEPTH];

    logic [CH_W-1:0]    r_ch;
    logic [KIND_W-1:0]  r_kind;
    logic               r_retry;
    logic [SPACE_W-1:0] r_space;
    logic [KIND_W-1:0]  r_rd;
    logic [PTR_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_i;
    logic               r_dup;

    logic               r_out_valid;
    dmrq_pkg::t_rsp     r_out;

    logic [CH_W-1:0]    ch_in;
    logic [PTR_W-1:0]   cur_head;
    logic [CNT_W-1:0]   cur_count;
    logic [LEN_W-1:0]   rd_need;
    logic [LEN_W-1:0]   kind_need;
    logic               in_acc;
    logic               taken;
    logic               drain_go;
    logic               fits_new;
    logic               dec_send;
    logic               dec_defer;
    logic               emit;
    logic               stall;
    logic               mem_re;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [PTR_W-1:0]   tail;
    dmrq_pkg::t_rsp     out_word;

    assign o_in_ready  = (r_step == dmrq_pkg::ST_WAIT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign ch_in     = (CHANNEL_COUNT > 1) ? CH_W'(i_in_data.channel) : CH_W'(0);
    assign cur_head  = r_head[r_ch];
    assign cur_count = r_count[r_ch];
    assign tail      = PTR_W'(cur_head + cur_count[PTR_W-1:0]);

    // zero length for kinds without a register
    assign rd_need   = (r_rd < KIND_W'(dmrq_pkg::LEN_REGS))
                     ? r_len[r_rd[dmrq_pkg::LEN_IDX_W-1:0]] : '0;
    assign kind_need = (r_kind < KIND_W'(dmrq_pkg::LEN_REGS))
                     ? r_len[r_kind[dmrq_pkg::LEN_IDX_W-1:0]] : '0;

    assign uw = dmrq_pkg::ucode(r_step);

    always_comb begin
        unique case (uw.cond)
            dmrq_pkg::C_REQ:      taken = in_acc;
            dmrq_pkg::C_EMPTY:    taken = (cur_count == '0);
            dmrq_pkg::C_NOFIT:    taken = (SPACE_W'(rd_need) > r_space);
            dmrq_pkg::C_RETRY:    taken = r_retry;
            dmrq_pkg::C_SCAN_END: taken = (r_i == cur_count);
            dmrq_pkg::C_MATCH:    taken = (r_rd == r_kind);
            dmrq_pkg::C_ALWAYS:   taken = 1'b1;
            default:              taken = 1'b1;
        endcase
    end

    always_comb begin
        drain_go  = uw.drain && !taken;
        fits_new  = (cur_count == '0) && (SPACE_W'(kind_need) <= r_space);
        dec_send  = uw.decide && !r_dup && fits_new;
        dec_defer = uw.decide && !r_dup && !fits_new
                  && (cur_count < CNT_W'(dmrq_pkg::QUEUE_DEPTH));
        emit      = drain_go || dec_send || uw.final_emit;
        // hold the step while the output register is still occupied
        stall     = emit && r_out_valid && !i_out_ready;
        n_step    = stall ? r_step : (taken ? uw.tgt : uw.fall);
        mem_re    = (uw.rd_head || uw.rd_scan) && !taken;
        rd_addr   = ADDR_W'({r_ch, (uw.rd_head ? cur_head : r_pos)});
        wr_addr   = ADDR_W'({r_ch, tail});

        if (uw.final_emit) begin
            out_word.item_kind    = dmrq_pkg::ITEM_FINAL;
            out_word.sent_kind    = '0;
            out_word.outcome      = r_outcome;
            out_word.queued_after = 5'(cur_count);
            out_word.last_item    = 1'b1;
        end else begin
            out_word.item_kind    = dmrq_pkg::ITEM_SENT;
            out_word.sent_kind    = drain_go ? r_rd : r_kind;
            out_word.outcome      = dmrq_pkg::OC_SENT;
            out_word.queued_after = '0;
            out_word.last_item    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dmrq_pkg::ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (dec_defer) begin
            r_mem[wr_addr] <= r_kind;
        end
        if (mem_re) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
            for (int k = 0; k < dmrq_pkg::LEN_REGS; k++) begin
                r_len[k] <= dmrq_pkg::LEN_RESET[k];
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len[i_cfg_idx] <= i_cfg_data;
            end
            if (drain_go && !stall) begin
                r_head[r_ch]  <= PTR_W'(cur_head + PTR_W'(1));
                r_count[r_ch] <= CNT_W'(cur_count - CNT_W'(1));
            end
            if (dec_defer) begin
                r_count[r_ch] <= CNT_W'(cur_count + CNT_W'(1));
            end
            if (emit && !stall) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request registers and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (in_acc) begin
            r_ch    <= ch_in;
            r_kind  <= i_in_data.message_kind;
            r_retry <= i_in_data.retry_only;
            r_space <= i_in_data.tx_space;
        end
        if (drain_go && !stall) begin
            r_space <= SPACE_W'(r_space - SPACE_W'(rd_need));
        end
        if (uw.scan_init) begin
            r_pos     <= cur_head;
            r_i       <= '0;
            r_dup     <= 1'b0;
            r_outcome <= dmrq_pkg::OC_RETRY;
        end
        if (uw.rd_scan && !taken) begin
            r_pos <= PTR_W'(r_pos + PTR_W'(1));
            r_i   <= CNT_W'(r_i + CNT_W'(1));
        end
        if (uw.dup_chk && taken) begin
            r_dup <= 1'b1;
        end
        if (uw.decide && !stall) begin
            if (r_dup) begin
                r_outcome <= dmrq_pkg::OC_DUP;
            end else if (fits_new) begin
                r_outcome <= dmrq_pkg::OC_SENT;
            end else if (dec_defer) begin
                r_outcome <= dmrq_pkg::OC_DEFERRED;
            end else begin
                r_outcome <= dmrq_pkg::OC_FULL;
            end
        end
        if (emit && !stall) begin
            r_out <= out_word;
        end
    end

    `ASSERT_AT(a_accept_starts_drain, i_clk, i_rst_n,
        in_acc |=> (r_step == dmrq_pkg::ST_DRAIN_RD), "request did not start the drain")
    `ASSERT_AT(a_final_holds_on_stall, i_clk, i_rst_n,
        (r_step == dmrq_pkg::ST_FINAL && r_out_valid && !i_out_ready)
        |=> (r_step == dmrq_pkg::ST_FINAL), "final result lost under stall")
    `ASSERT_NEVER(a_count_in_range, i_clk, i_rst_n,
        cur_count > CNT_W'(dmrq_pkg::QUEUE_DEPTH), "ring count beyond depth")
    `ASSERT_AT(a_defer_grows_ring, i_clk, i_rst_n,
        dec_defer |=> (cur_count == CNT_W'($past(cur_count) + CNT_W'(1))),
        "deferred request not counted")

endmodule

[tb/sv/tb_top.sv]
// testbench for deferred_message_ring_queue: directed and random requests under several
// length settings, each result checked against a ring-queue predictor in a scoreboard class
// depends on dmrq_pkg and the rtl of the block
module tb_top;

    localparam int CHANNELS     = 2;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [dmrq_pkg::LEN_IDX_W-1:0] REG_LEN_HEARTBEAT   = 2'd0;
    localparam logic [dmrq_pkg::LEN_IDX_W-1:0] REG_LEN_ATTITUDE    = 2'd1;
    localparam logic [dmrq_pkg::LEN_IDX_W-1:0] REG_LEN_LOCATION    = 2'd2;
    localparam logic [dmrq_pkg::LEN_IDX_W-1:0] REG_LEN_STATUS_TEXT = 2'd3;

    localparam logic [dmrq_pkg::KIND_W-1:0] KIND_HEARTBEAT = 4'd0;
    localparam logic [dmrq_pkg::KIND_W-1:0] KIND_ATTITUDE  = 4'd1;
    localparam logic [dmrq_pkg::KIND_W-1:0] KIND_LOCATION  = 4'd2;
    localparam logic [dmrq_pkg::KIND_W-1:0] KIND_STATUS    = 4'd3;
    localparam logic [dmrq_pkg::KIND_W-1:0] KIND_SPARE_LO  = 4'd4;
    localparam logic [dmrq_pkg::KIND_W-1:0] KIND_SPARE_MID = 4'd8;
    localparam logic [dmrq_pkg::KIND_W-1:0] KIND_SPARE_HI  = 4'd15;

    localparam logic CH_A = 1'b0;
    localparam logic CH_B = 1'b1;

    class dmrq_tracker;
        logic [dmrq_pkg::KIND_W-1:0] ring [CHANNELS][dmrq_pkg::QUEUE_DEPTH];
        int unsigned                 head [CHANNELS];
        int unsigned                 count [CHANNELS];
        logic [dmrq_pkg::LEN_W-1:0]  len_of [dmrq_pkg::LEN_REGS];
        dmrq_pkg::t_rsp              due_results [$];
        int unsigned                 mismatch_count;

        function new();
            foreach (len_of[i]) len_of[i] = dmrq_pkg::LEN_RESET[i];
            foreach (head[c]) begin
                head[c]  = 0;
                count[c] = 0;
            end
            mismatch_count = 0;
        endfunction

        function void set_length(logic [dmrq_pkg::LEN_IDX_W-1:0] idx,
                                 logic [dmrq_pkg::LEN_W-1:0] val);
            len_of[idx] = val;
        endfunction

        function int unsigned kind_length(logic [dmrq_pkg::KIND_W-1:0] kind);
            if (kind < dmrq_pkg::LEN_REGS) begin
                return len_of[kind[dmrq_pkg::LEN_IDX_W-1:0]];
            end
            return 0;
        endfunction

        function void push_result(logic ik, logic [dmrq_pkg::KIND_W-1:0] sk,
                                  dmrq_pkg::t_outcome oc, int unsigned left, logic li);
            dmrq_pkg::t_rsp r;
            r.item_kind    = ik;
            r.sent_kind    = sk;
            r.outcome      = oc;
            r.queued_after = 5'(left);
            r.last_item    = li;
            due_results.push_back(r);
        endfunction

        function void accept_request(dmrq_pkg::t_req req);
            int unsigned                 ch;
            int unsigned                 space;
            int unsigned                 pos;
            logic [dmrq_pkg::KIND_W-1:0] k;
            bit                          blocked;
            bit                          dup;
            dmrq_pkg::t_outcome          oc;
            ch      = req.channel;
            space   = req.tx_space;
            blocked = 1'b0;
            // send from the head while each queued kind still fits
            while (count[ch] != 0 && !blocked) begin
                k = ring[ch][head[ch]];
                if (kind_length(k) > space) begin
                    blocked = 1'b1;
                end else begin
                    space -= kind_length(k);
                    push_result(dmrq_pkg::ITEM_SENT, k, dmrq_pkg::OC_SENT, 0, 1'b0);
                    head[ch] = (head[ch] + 1) % dmrq_pkg::QUEUE_DEPTH;
                    count[ch]--;
                end
            end
            if (req.retry_only) begin
                oc = dmrq_pkg::OC_RETRY;
            end else begin
                dup = 1'b0;
                for (int i = 0; i < count[ch]; i++) begin
                    if (ring[ch][(head[ch] + i) % dmrq_pkg::QUEUE_DEPTH]
                        == req.message_kind) begin
                        dup = 1'b1;
                    end
                end
                if (dup) begin
                    oc = dmrq_pkg::OC_DUP;
                end else if (count[ch] == 0 && kind_length(req.message_kind) <= space) begin
                    push_result(dmrq_pkg::ITEM_SENT, req.message_kind, dmrq_pkg::OC_SENT,
                                0, 1'b0);
                    oc = dmrq_pkg::OC_SENT;
                end else if (count[ch] >= dmrq_pkg::QUEUE_DEPTH) begin
                    oc = dmrq_pkg::OC_FULL;
                end else begin
                    pos = (head[ch] + count[ch]) % dmrq_pkg::QUEUE_DEPTH;
                    ring[ch][pos] = req.message_kind;
                    count[ch]++;
                    oc = dmrq_pkg::OC_DEFERRED;
                end
            end
            push_result(dmrq_pkg::ITEM_FINAL, '0, oc, count[ch], 1'b1);
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
            end
        endtask

        task compare_result(dmrq_pkg::t_rsp got);
            dmrq_pkg::t_rsp want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result %h with no request outstanding", got));
            end else begin
                want = due_results.pop_front();
                check_field("item_kind", got.item_kind, want.item_kind);
                check_field("sent_kind", got.sent_kind, want.sent_kind);
                check_field("outcome", got.outcome, want.outcome);
                check_field("queued_after", got.queued_after, want.queued_after);
                check_field("last_item", got.last_item, want.last_item);
            end
        endtask

        function int unsigned pending();
            return due_results.size();
        endfunction
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    dmrq_pkg::t_req                 in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    dmrq_pkg::t_rsp                 out_data;
    logic                           cfg_we    = 1'b0;
    logic [dmrq_pkg::LEN_IDX_W-1:0] cfg_idx   = '0;
    logic [dmrq_pkg::LEN_W-1:0]     cfg_data  = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    dmrq_tracker tracker = new();

    deferred_message_ring_queue #(.CHANNEL_COUNT(CHANNELS)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check on accept, then pick the next ready
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            tracker.compare_result(out_data);
        end
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // valid stays high between back-to-back requests; it drops only on a gap or a pause
    task automatic send_request(dmrq_pkg::t_req req);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.accept_request(req);
    endtask

    task automatic send_fields(logic ch, logic [dmrq_pkg::KIND_W-1:0] kind, logic retry,
                               logic [dmrq_pkg::SPACE_W-1:0] space);
        dmrq_pkg::t_req req;
        req.channel      = ch;
        req.message_kind = kind;
        req.retry_only   = retry;
        req.tx_space     = space;
        send_request(req);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [dmrq_pkg::LEN_IDX_W-1:0] idx,
                             logic [dmrq_pkg::LEN_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        tracker.set_length(idx, val);
    endtask

    task automatic write_lengths(logic [dmrq_pkg::LEN_W-1:0] hb,
                                 logic [dmrq_pkg::LEN_W-1:0] att,
                                 logic [dmrq_pkg::LEN_W-1:0] loc,
                                 logic [dmrq_pkg::LEN_W-1:0] txt);
        write_reg(REG_LEN_HEARTBEAT, hb);
        write_reg(REG_LEN_ATTITUDE, att);
        write_reg(REG_LEN_LOCATION, loc);
        write_reg(REG_LEN_STATUS_TEXT, txt);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(int unsigned n_items);
        int unsigned done_cnt;
        int unsigned burst;
        int unsigned start;
        int unsigned step;
        bit          sweep;
        bit          paused;
        logic        ch;
        done_cnt = 0;
        paused   = 1'b0;
        while (done_cnt < n_items) begin
            if ($urandom_range(99) < 75) begin
                // run of requests on one channel with little space, then a drain
                ch    = 1'($urandom_range(1));
                burst = $urandom_range(3, 16);
                sweep = ($urandom_range(99) < 40);
                start = $urandom_range(15);
                step  = 2 * $urandom_range(7) + 1;
                for (int i = 0; i < burst; i++) begin
                    // odd stride walks distinct kinds, so the ring can fill up
                    send_fields(ch, sweep ? 4'(start + i * step) : 4'($urandom_range(15)),
                                1'b0, 12'($urandom_range(60)));
                end
                send_fields(ch, 4'($urandom_range(15)), 1'($urandom_range(1)),
                            12'($urandom_range(4095)));
                done_cnt += burst + 1;
            end else begin
                send_fields(1'($urandom_range(1)), 4'($urandom_range(15)),
                            1'($urandom_range(1)), 12'($urandom_range(4095)));
                done_cnt++;
            end
            if (!paused && done_cnt >= n_items / 2) begin
                wait_quiet();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset lengths: heartbeat 9, attitude 28, location 28, status text 51
        send_fields(CH_A, KIND_HEARTBEAT, 1'b0, 12'd4095);
        send_fields(CH_A, KIND_STATUS, 1'b0, 12'd50);
        send_fields(CH_A, KIND_STATUS, 1'b0, 12'd0);
        send_fields(CH_A, KIND_SPARE_HI, 1'b0, 12'd0);
        send_fields(CH_A, KIND_LOCATION, 1'b0, 12'd51);
        send_fields(CH_B, KIND_ATTITUDE, 1'b0, 12'd28);
        send_fields(CH_B, KIND_ATTITUDE, 1'b0, 12'd27);
        send_fields(CH_B, KIND_SPARE_LO, 1'b0, 12'd0);
        send_fields(CH_B, KIND_ATTITUDE, 1'b0, 12'd0);
        send_fields(CH_B, KIND_SPARE_LO, 1'b1, 12'd4095);
        send_fields(CH_B, KIND_SPARE_HI, 1'b1, 12'd0);
        send_fields(CH_A, KIND_HEARTBEAT, 1'b1, 12'd28);
        send_fields(CH_A, KIND_SPARE_MID, 1'b0, 12'd0);
        wait_quiet();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            if (p == 0) begin
                write_lengths(8'd255, 8'd255, 8'd255, 8'd255);
            end else if (p == 1) begin
                write_lengths(8'd0, 8'd0, 8'd0, 8'd0);
            end else if (p % 2 == 0) begin
                write_lengths(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)));
            end else begin
                write_lengths(8'($urandom_range(40)), 8'($urandom_range(40)),
                              8'($urandom_range(40)), 8'($urandom_range(40)));
            end
            run_random_phase(8);
            wait_quiet();
        end

        repeat (20) @(posedge clk);
        if (tracker.mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/dmrq_pkg.sv
rtl/deferred_message_ring_queue.sv
tb/sv/tb_top.sv
